FILE: design/rx_fifo_xon_xoff_flow_control_assert.svh
// assertion macros for the receive fifo with xon/xoff flow control
`ifndef RX_FIFO_XON_XOFF_FLOW_CONTROL_ASSERT_SVH
`define RX_FIFO_XON_XOFF_FLOW_CONTROL_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define RXFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RXFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rxfc_pkg.sv
// shared types and constants for the receive fifo with xon/xoff flow control
package rxfc_pkg;

    // item kinds carried on the input tuser field
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_READ = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_WM  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_WM   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_XON      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_XOFF     = 3'd4;

    // field widths
    localparam int CFG_DATA_W = 16;
    localparam int WM_W       = 7;
    localparam int TICK_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;

    // register reset values
    localparam logic [WM_W-1:0]   HIGH_WM_RST = 7'd48;
    localparam logic [WM_W-1:0]   LOW_WM_RST  = 7'd16;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd6400;
    localparam logic [CHAR_W-1:0] XON_RST     = 8'h11;
    localparam logic [CHAR_W-1:0] XOFF_RST    = 8'h13;

    // default buffer depth
    localparam int DEPTH_DEF = 64;

endpackage

FILE: design/rxfc_ram.sv
// generic single write port ram with registered read
module rxfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rx_fifo_xon_xoff_flow_control.sv
// receive ring buffer with xon/xoff flow control and idle timeout
// the result is valid on m_tvalid in the cycle after the input is accepted
// throughput: one item per cycle while m_tready is high, set by the single
// result register; the ram's registered read holds the read data of a popped byte
// reset: synchronous active-low aresetn clears pointers, count, flags and
// output valid, loads register defaults, holds s_tready low; byte store kept
module rx_fifo_xon_xoff_flow_control
    import rxfc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_BITS = 21 + CNT_W,
    localparam int M_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,  // rx_byte
    input  logic [KIND_W-1:0]     s_tuser,  // kind
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_byte, read_ok, empty_read, overrun, fill_level, flow_send,
    // flow_byte, timed_out, zero pad
    output logic [M_W-1:0]        m_tdata
);

    localparam int CMP_W = (CNT_W > WM_W) ? CNT_W : WM_W;

    // configuration registers
    logic [WM_W-1:0]   high_wm_reg;
    logic [WM_W-1:0]   low_wm_reg;
    logic [TICK_W-1:0] timeout_ticks_reg;
    logic [CHAR_W-1:0] xon_char_reg;
    logic [CHAR_W-1:0] xoff_char_reg;

    // buffer and flow state
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sender_en_reg, sender_en_next;
    logic [TICK_W-1:0] to_cnt_reg, to_cnt_next;
    logic              to_flag_reg, to_flag_next;

    // result register
    logic              m_valid_reg;
    logic              m_rd_ok_reg, rd_ok_next;
    logic              m_empty_reg, empty_next;
    logic              m_ovr_reg, ovr_next;
    logic [CNT_W-1:0]  m_fill_reg;
    logic              m_send_reg, send_next;
    logic [CHAR_W-1:0] m_fbyte_reg, fbyte_next;
    logic              m_to_reg;

    logic              s_accept;
    logic              ram_we, ram_re;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] read_byte;
    kind_t             kind;

    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);

    // configuration writes, out-of-range indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_wm_reg       <= HIGH_WM_RST;
            low_wm_reg        <= LOW_WM_RST;
            timeout_ticks_reg <= TIMEOUT_RST;
            xon_char_reg      <= XON_RST;
            xoff_char_reg     <= XOFF_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HIGH_WM: high_wm_reg       <= cfg_wdata[WM_W-1:0];
                CFG_LOW_WM:  low_wm_reg        <= cfg_wdata[WM_W-1:0];
                CFG_TIMEOUT: timeout_ticks_reg <= cfg_wdata[TICK_W-1:0];
                CFG_XON:     xon_char_reg      <= cfg_wdata[CHAR_W-1:0];
                CFG_XOFF:    xoff_char_reg     <= cfg_wdata[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // per-item update of pointers, count and timeout
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        to_cnt_next = to_cnt_reg;
        to_flag_next = to_flag_reg;
        rd_ok_next  = 1'b0;
        empty_next  = 1'b0;
        ovr_next    = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        unique case (kind)
            KIND_BYTE: begin
                to_cnt_next  = timeout_ticks_reg;
                to_flag_next = 1'b0;
                if (cnt_reg == CNT_W'(DEPTH)) begin
                    ovr_next = 1'b1;
                end else begin
                    ram_we      = s_accept;
                    wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            KIND_READ: begin
                if (cnt_reg == '0) begin
                    empty_next = 1'b1;
                end else begin
                    ram_re      = s_accept;
                    rd_ok_next  = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                    cnt_next    = cnt_reg - 1'b1;
                end
            end
            KIND_TICK: begin
                if (to_cnt_reg != '0) begin
                    to_cnt_next = to_cnt_reg - 1'b1;
                end
                if (to_cnt_next == '0) begin
                    to_flag_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // watermark checks, xoff first then xon
    always_comb begin
        sender_en_next = sender_en_reg;
        send_next      = 1'b0;
        fbyte_next     = '0;
        if ((CMP_W'(cnt_next) >= CMP_W'(high_wm_reg)) && sender_en_next) begin
            sender_en_next = 1'b0;
            send_next      = 1'b1;
            fbyte_next     = xoff_char_reg;
        end
        if ((CMP_W'(cnt_next) <= CMP_W'(low_wm_reg)) && !sender_en_next) begin
            sender_en_next = 1'b1;
            send_next      = 1'b1;
            fbyte_next     = xon_char_reg;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            sender_en_reg <= 1'b0;
            to_cnt_reg    <= TIMEOUT_RST;
            to_flag_reg   <= 1'b0;
        end else if (s_accept) begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            sender_en_reg <= sender_en_next;
            to_cnt_reg    <= to_cnt_next;
            to_flag_reg   <= to_flag_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_rd_ok_reg <= rd_ok_next;
            m_empty_reg <= empty_next;
            m_ovr_reg   <= ovr_next;
            m_fill_reg  <= cnt_next;
            m_send_reg  <= send_next;
            m_fbyte_reg <= fbyte_next;
            m_to_reg    <= to_flag_next;
        end
    end

    // byte store, read data lands with the item's result
    rxfc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign read_byte = m_rd_ok_reg ? ram_rdata : '0;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_W - OUT_BITS){1'b0}}, m_to_reg, m_fbyte_reg, m_send_reg,
                        m_fill_reg, m_ovr_reg, m_empty_reg, m_rd_ok_reg, read_byte};

`include "rx_fifo_xon_xoff_flow_control_assert.svh"

    // checks on the buffer and flow state
    `RXFC_ASSERT_ALWAYS(a_cnt_max, cnt_reg <= CNT_W'(DEPTH), "fill count above depth")
    `RXFC_ASSERT_ALWAYS(a_rd_excl, !(m_rd_ok_reg && m_empty_reg && m_valid_reg), "rd and empty")
    `RXFC_ASSERT_ALWAYS(a_to_zero, !to_flag_reg || (to_cnt_reg == '0), "timeout flag with nonzero count")
    `RXFC_ASSERT_NEXT(a_flow_hold, s_accept && !send_next, sender_en_reg == $past(sender_en_reg), "flow moved")

endmodule

FILE: tb/rx_fifo_xon_xoff_flow_control_tb.sv
// testbench for the receive fifo with xon/xoff flow control and idle timeout
module rx_fifo_xon_xoff_flow_control_tb;
    import rxfc_pkg::*;

    localparam int FIFO_DEPTH    = 64;
    localparam int RES_W         = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TRAFFIC_ITEMS = 155;
    // kind code with no function in the block
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic [7:0] read_byte;
        logic       read_ok;
        logic       empty_read;
        logic       overrun;
        logic [6:0] fill_level;
        logic       flow_send;
        logic [7:0] flow_byte;
        logic       timed_out;
    } rx_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;  // rx_byte
    logic [KIND_W-1:0]     s_tuser   = '0;  // kind
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // read_byte, read_ok, empty_read, overrun, fill_level, flow_send,
    // flow_byte, timed_out, zero pad
    logic [RES_W-1:0]      m_tdata;

    // predicted buffer, flow and timeout state
    logic [7:0]  fifo_bytes [FIFO_DEPTH];
    logic [5:0]  wr_slot;
    logic [5:0]  rd_slot;
    logic [6:0]  fill_cnt;
    logic        peer_on;
    logic [15:0] idle_cnt;
    logic        idle_flag;

    // predicted register contents
    logic [6:0]  high_wm;
    logic [6:0]  low_wm;
    logic [15:0] idle_reload;
    logic [7:0]  xon_code;
    logic [7:0]  xoff_code;

    rx_result_t  pending_results [$];
    int          err_count  = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int unsigned cycles     = 0;

    // receiver stall pattern
    logic [31:0] stall_mask = '0;
    int unsigned stall_run  = 0;
    logic        no_stall   = 1'b1;

    rx_fifo_xon_xoff_flow_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rx_fifo_xon_xoff_flow_control regression: fail");
            $finish;
        end
    end

    // receiver ready: random masks in runs, some runs without stalls
    always @(posedge aclk) begin
        if (stall_run == 0) begin
            stall_mask <= $urandom;
            stall_run  <= $urandom_range(8, 48);
            no_stall   <= ($urandom_range(0, 3) == 0);
        end else begin
            stall_run <= stall_run - 1;
        end
        m_tready <= no_stall || stall_mask[stall_run[4:0]];
    end

    function automatic void clear_model();
        high_wm     = HIGH_WM_RST;
        low_wm      = LOW_WM_RST;
        idle_reload = TIMEOUT_RST;
        xon_code    = XON_RST;
        xoff_code   = XOFF_RST;
        wr_slot     = '0;
        rd_slot     = '0;
        fill_cnt    = '0;
        peer_on     = 1'b0;
        idle_cnt    = TIMEOUT_RST;
        idle_flag   = 1'b0;
    endfunction

    // expected result of one item, advancing the predicted state
    function automatic rx_result_t predict_item(logic [KIND_W-1:0] kind, logic [7:0] rx);
        rx_result_t r;
        r = '{default: '0};
        case (kind)
            KIND_BYTE: begin
                // any byte counts as line activity, even a dropped one
                idle_cnt  = idle_reload;
                idle_flag = 1'b0;
                if (fill_cnt >= FIFO_DEPTH) begin
                    r.overrun = 1'b1;
                end else begin
                    fifo_bytes[wr_slot] = rx;
                    wr_slot  = wr_slot + 1'b1;
                    fill_cnt = fill_cnt + 1'b1;
                end
            end
            KIND_READ: begin
                if (fill_cnt == 0) begin
                    r.empty_read = 1'b1;
                end else begin
                    r.read_byte = fifo_bytes[rd_slot];
                    r.read_ok   = 1'b1;
                    rd_slot  = rd_slot + 1'b1;
                    fill_cnt = fill_cnt - 1'b1;
                end
            end
            KIND_TICK: begin
                if (idle_cnt != 0) idle_cnt = idle_cnt - 1'b1;
                if (idle_cnt == 0) idle_flag = 1'b1;
            end
            default: ;
        endcase
        // xoff check first, then xon; xon wins when both fire
        if (fill_cnt >= high_wm && peer_on) begin
            peer_on     = 1'b0;
            r.flow_send = 1'b1;
            r.flow_byte = xoff_code;
        end
        if (fill_cnt <= low_wm && !peer_on) begin
            peer_on     = 1'b1;
            r.flow_send = 1'b1;
            r.flow_byte = xon_code;
        end
        r.fill_level = fill_cnt;
        r.timed_out  = idle_flag;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        err_count++;
        $display("mismatch at cycle %0d on %s: expected %h got %h", cycles, what, want, got);
    endtask

    task automatic check_result(logic [RES_W-1:0] word);
        rx_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no item pending", '0, word);
            return;
        end
        want = pending_results.pop_front();
        if (word[7:0] !== want.read_byte) report_mismatch("read_byte", want.read_byte, word[7:0]);
        if (word[8] !== want.read_ok) report_mismatch("read_ok", want.read_ok, word[8]);
        if (word[9] !== want.empty_read) report_mismatch("empty_read", want.empty_read, word[9]);
        if (word[10] !== want.overrun) report_mismatch("overrun", want.overrun, word[10]);
        if (word[17:11] !== want.fill_level)
            report_mismatch("fill_level", want.fill_level, word[17:11]);
        if (word[18] !== want.flow_send) report_mismatch("flow_send", want.flow_send, word[18]);
        if (word[26:19] !== want.flow_byte)
            report_mismatch("flow_byte", want.flow_byte, word[26:19]);
        if (word[27] !== want.timed_out) report_mismatch("timed_out", want.timed_out, word[27]);
    endtask

    // predict on item accept, then check any result taken at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) pending_results.push_back(predict_item(s_tuser, s_tdata));
            if (m_tvalid && m_tready) check_result(m_tdata);
        end
    end

    // send one item; bursts of random length with random gaps between them
    task automatic send_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] rx);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= rx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // wait until every item has its result back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // write all five registers while the block is idle
    task automatic apply_config(int unsigned hi, int unsigned lo, int unsigned ticks,
                                int unsigned xon, int unsigned xoff);
        logic [CFG_ADDR_W-1:0] regs [5];
        int unsigned           vals [5];
        regs = '{CFG_HIGH_WM, CFG_LOW_WM, CFG_TIMEOUT, CFG_XON, CFG_XOFF};
        vals = '{hi, lo, ticks, xon, xoff};
        wait_idle();
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i][CFG_DATA_W-1:0];
            @(posedge aclk);
            case (regs[i])
                CFG_HIGH_WM: high_wm     = vals[i][6:0];
                CFG_LOW_WM:  low_wm      = vals[i][6:0];
                CFG_TIMEOUT: idle_reload = vals[i][15:0];
                CFG_XON:     xon_code    = vals[i][7:0];
                CFG_XOFF:    xoff_code   = vals[i][7:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // random traffic: fill runs, drain runs, tick runs and mixed runs
    task automatic run_traffic(int n);
        int                stop_at;
        int                run_len;
        int                pick;
        int                w;
        logic [KIND_W-1:0] kind;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick    = $urandom_range(0, 9);
            run_len = $urandom_range(1, 72);
            if (pick <= 2) begin
                repeat (run_len) send_item(KIND_BYTE, BYTE_W'($urandom_range(0, 255)));
            end else if (pick <= 4) begin
                repeat (run_len) send_item(KIND_READ, BYTE_W'($urandom_range(0, 255)));
            end else if (pick == 5) begin
                repeat (run_len / 2 + 1) send_item(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
            end else begin
                repeat (run_len % 30 + 1) begin
                    w = $urandom_range(0, 19);
                    kind = (w < 8) ? KIND_BYTE : (w < 15) ? KIND_READ
                         : (w < 19) ? KIND_TICK : KIND_SPARE;
                    send_item(kind, BYTE_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // defaults out of reset: first item sends xon, empty reads, byte extremes
    task automatic test_reset_state();
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_READ, 8'hFF);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'hA5);
        send_item(KIND_BYTE, 8'h5A);
        send_item(KIND_SPARE, 8'hC3);
        repeat (4) send_item(KIND_READ, 8'h00);
        send_item(KIND_READ, 8'h00);
    endtask

    task automatic test_default_traffic();
        run_traffic(TRAFFIC_ITEMS);
    endtask

    // zero reload takes effect at the next byte; flag holds at zero
    task automatic test_timeout_edges();
        apply_config(48, 16, 0, 17, 19);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, 8'h3C);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'h00);
        apply_config(48, 16, 2, 17, 19);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, 8'hC3);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_READ, 8'h00);
        send_item(KIND_READ, 8'h00);
    endtask

    task automatic test_watermark_extremes();
        apply_config(64, 0, 1, 0, 255);
        run_traffic(TRAFFIC_ITEMS);
    endtask

    // high at zero and low at full: both checks fire on every item once the sender is enabled
    task automatic test_overlapping_watermarks();
        apply_config(0, 64, 65535, 255, 0);
        run_traffic(TRAFFIC_ITEMS);
    endtask

    // high mark beyond the buffer size never pauses the sender
    task automatic test_out_of_range_watermark();
        apply_config(127, 5, 0, $urandom_range(0, 255), $urandom_range(0, 255));
        run_traffic(TRAFFIC_ITEMS);
    endtask

    task automatic test_equal_watermarks();
        apply_config(40, 40, 3, $urandom_range(0, 255), $urandom_range(0, 255));
        run_traffic(TRAFFIC_ITEMS);
    endtask

    task automatic test_random_settings();
        repeat (2) begin
            apply_config($urandom_range(0, 64), $urandom_range(0, 64), $urandom_range(1, 40),
                         $urandom_range(0, 255), $urandom_range(0, 255));
            run_traffic(TRAFFIC_ITEMS);
        end
    endtask

    initial begin
        clear_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_default_traffic();
        test_timeout_edges();
        test_watermark_extremes();
        test_overlapping_watermarks();
        test_out_of_range_watermark();
        test_equal_watermarks();
        test_random_settings();

        // drain, then wait out the registered result
        wait_idle();
        repeat (4) @(posedge aclk);
        if (err_count == 0) begin
            $display("rx_fifo_xon_xoff_flow_control regression: pass");
        end else begin
            $display("rx_fifo_xon_xoff_flow_control regression: fail");
        end
        $finish;
    end

endmodule
